// ----- hw/rtl/fc_pkg.sv -----
// shared constants for the feedforward compressor
`timescale 1ns / 1ps
package fc_pkg;

  localparam int SAMPLE_BITS_DEF = 24;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIM      = 3'd4;

  // shared divider
  localparam int DIV_N_W = 32;
  localparam int DIV_D_W = 16;

  // fixed-point constants
  localparam logic signed [15:0] DB_FLOOR        = -16'sd24576;
  localparam logic [16:0]        DB_FLOOR_MAG    = 17'd24576;
  localparam logic [32:0]        DB_PER_LOG2_Q16 = 33'd394566;
  localparam logic [32:0]        LOG2_PER_DB_Q24 = 33'd2786636;
  localparam logic [32:0]        LN2_Q30         = 33'd744261118;
  localparam logic [30:0]        ONE_Q30         = 31'h4000_0000;
  localparam logic [14:0]        RATIO_ONE       = 15'd256;
  localparam logic [3:0]         EXP_TERMS       = 4'd10;

endpackage

// ----- hw/rtl/feedforward_compressor_unit.sv -----
// feedforward hard-knee compressor: level detect, gain computer, smoother, make-up gain
`timescale 1ns / 1ps
// sequence from accept to out_valid: a leading-one walk, sixteen log2 squarings, the
// ratio divide on the shared radix-2 divider when over threshold, then ten exp series
// terms, each a multiply plus a divide; a zero sample skips the walk and squarings
// a new item is taken only back in idle; in_ready is low while an item is in
// work and a result held by out_ready stalls the sequencer in its last state
// reset: synchronous; clears smoother, registers to defaults, sequencer and output valid
module feedforward_compressor_unit #(
  parameter int SAMPLE_BITS = fc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [SAMPLE_BITS-1:0]   sample_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [SAMPLE_BITS-1:0]   sample_out,
  output logic signed [15:0]              gain_db,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import fc_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_NORM = 5'd1;
  localparam logic [4:0] S_SQ   = 5'd2;
  localparam logic [4:0] S_SQW  = 5'd3;
  localparam logic [4:0] S_DB   = 5'd4;
  localparam logic [4:0] S_DBW  = 5'd5;
  localparam logic [4:0] S_GAIN = 5'd6;
  localparam logic [4:0] S_DIVW = 5'd7;
  localparam logic [4:0] S_SM1  = 5'd8;
  localparam logic [4:0] S_SM2  = 5'd9;
  localparam logic [4:0] S_SM3  = 5'd10;
  localparam logic [4:0] S_MK   = 5'd11;
  localparam logic [4:0] S_MKW  = 5'd12;
  localparam logic [4:0] S_FR   = 5'd13;
  localparam logic [4:0] S_FRW  = 5'd14;
  localparam logic [4:0] S_EX   = 5'd15;
  localparam logic [4:0] S_EXW  = 5'd16;
  localparam logic [4:0] S_EXD  = 5'd17;
  localparam logic [4:0] S_OUTM = 5'd18;
  localparam logic [4:0] S_OUTW = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  // configuration
  logic signed [15:0] threshold_db;
  logic [14:0]        ratio;
  logic [15:0]        alpha_attack;
  logic [15:0]        alpha_release;
  logic signed [13:0] trim_db;

  // sequencer and datapath registers
  logic [4:0]              state;
  logic [SAMPLE_BITS-1:0]  mag;
  logic                    neg;
  logic [31:0]             nrm;
  logic [4:0]              sh;
  logic [4:0]              p;
  logic [30:0]             y;
  logic [15:0]             frac;
  logic [3:0]              k;
  logic signed [15:0]      db;
  logic [16:0]             over;
  logic signed [17:0]      change;
  logic signed [15:0]      sg;
  logic signed [39:0]      acc;
  logic signed [7:0]       ip;
  logic [15:0]             f;
  logic [29:0]             y2;
  logic [30:0]             term;
  logic [31:0]             sum;
  logic [SAMPLE_BITS-1:0]  vres;
  logic signed [65:0]      mul_p;

  // combinational
  logic signed [32:0]      mul_a;
  logic signed [32:0]      mul_b;
  logic [SAMPLE_BITS-1:0]  in_mag;
  logic [31:0]             y_sq;
  logic [20:0]             log_dist;
  logic [41:0]             dbt;
  logic [16:0]             db_mag;
  logic signed [17:0]      over_w;
  logic [14:0]             r_eff;
  logic [16:0]             a_sel;
  logic [16:0]             one_minus;
  logic signed [16:0]      g;
  logic signed [39:0]      s_w;
  logic signed [39:0]      e_w;
  logic [63:0]             prod;
  logic signed [8:0]       rsh;
  logic [5:0]              rs;
  logic [64:0]             rnd;
  logic [64:0]             v;
  logic [64:0]             limit;
  logic                    div_start;
  logic [DIV_N_W-1:0]      div_n;
  logic [DIV_D_W-1:0]      div_d;
  logic                    div_done;
  logic [DIV_N_W-1:0]      div_q;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_mag    = sample_in[SAMPLE_BITS-1] ? (~sample_in + 1'b1) : sample_in;

  assign y_sq     = mul_p[61:30];
  assign log_dist = {5'(SAMPLE_BITS - 1) - p, 16'd0} - {5'd0, frac};
  assign dbt    = mul_p[41:0] + 42'h80_0000;
  assign db_mag = dbt[40:24];
  assign over_w = 18'(db) - 18'(threshold_db);
  assign r_eff  = (ratio < RATIO_ONE) ? RATIO_ONE : ratio;
  assign a_sel  = (change < 18'(sg)) ? {1'b0, alpha_attack} : {1'b0, alpha_release};
  assign one_minus = 17'h1_0000 - a_sel;
  assign g      = 17'(sg) + 17'(trim_db);
  assign s_w    = acc + $signed(mul_p[39:0]) + 40'sd32768;
  assign e_w    = $signed(mul_p[39:0]) + 40'sd32768;

  // output rounding and saturation
  assign prod  = mul_p[63:0];
  assign rsh   = 9'sd30 - 9'(ip);
  assign rs    = rsh[5:0];
  assign rnd   = {1'b0, prod} + (65'd1 << (rs - 6'd1));
  assign limit = neg ? (65'd1 << (SAMPLE_BITS - 1)) : ((65'd1 << (SAMPLE_BITS - 1)) - 65'd1);

  always_comb begin
    if (prod == 64'd0) begin
      v = '0;
    end else if (rsh <= 9'sd0) begin
      v = limit;
    end else if (rsh >= 9'sd63) begin
      v = '0;
    end else begin
      v = rnd >> rs;
    end
    if (v > limit) begin
      v = limit;
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQ: begin
        mul_a = 33'(y);
        mul_b = 33'(y);
      end
      S_DB: begin
        mul_a = 33'(log_dist);
        mul_b = DB_PER_LOG2_Q16;
      end
      S_SM1: begin
        mul_a = 33'(one_minus);
        mul_b = 33'(change);
      end
      S_SM2: begin
        mul_a = 33'(a_sel);
        mul_b = 33'(sg);
      end
      S_MK: begin
        mul_a = 33'(g);
        mul_b = LOG2_PER_DB_Q24;
      end
      S_FR: begin
        mul_a = 33'(f);
        mul_b = LN2_Q30;
      end
      S_EX: begin
        mul_a = 33'(term);
        mul_b = 33'(y2);
      end
      S_OUTM: begin
        mul_a = 33'(mag);
        mul_b = 33'(sum);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    if (state == S_GAIN) begin
      div_start = (db > threshold_db);
      div_n     = 32'({over_w[16:0], 8'd0}) + 32'(r_eff[14:1]);
      div_d     = 16'(r_eff);
    end else if (state == S_EXW) begin
      div_start = 1'b1;
      div_n     = 32'(mul_p[59:30]);
      div_d     = 16'(k);
    end
  end

  fc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db  <= '0;
      ratio         <= RATIO_ONE;
      alpha_attack  <= '0;
      alpha_release <= '0;
      trim_db       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_THRESHOLD: threshold_db  <= cfg_data;
        CFG_RATIO:     ratio         <= cfg_data[14:0];
        CFG_ATTACK:    alpha_attack  <= cfg_data;
        CFG_RELEASE:   alpha_release <= cfg_data;
        CFG_TRIM:      trim_db       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sg        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mag  <= in_mag;
            neg  <= sample_in[SAMPLE_BITS-1];
            nrm  <= 32'(in_mag);
            sh   <= '0;
            frac <= '0;
            k    <= '0;
            if (in_mag == '0) begin
              db    <= DB_FLOOR;
              state <= S_GAIN;
            end else begin
              state <= S_NORM;
            end
          end
        end
        S_NORM: begin
          if (nrm[31]) begin
            y     <= nrm[31:1];
            p     <= 5'd31;
            state <= S_SQ;
          end else if (nrm[30]) begin
            y     <= nrm[30:0];
            p     <= 5'd30 - sh;
            state <= S_SQ;
          end else begin
            nrm <= {nrm[30:0], 1'b0};
            sh  <= sh + 5'd1;
          end
        end
        S_SQ: state <= S_SQW;
        S_SQW: begin
          y    <= y_sq[31] ? y_sq[31:1] : y_sq[30:0];
          frac <= {frac[14:0], y_sq[31]};
          k    <= k + 4'd1;
          state <= (k == 4'd15) ? S_DB : S_SQ;
        end
        S_DB: state <= S_DBW;
        S_DBW: begin
          db    <= (db_mag > DB_FLOOR_MAG) ? DB_FLOOR : 16'(17'd0 - db_mag);
          state <= S_GAIN;
        end
        S_GAIN: begin
          over <= over_w[16:0];
          if (db > threshold_db) begin
            state <= S_DIVW;
          end else begin
            change <= '0;
            state  <= S_SM1;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            change <= 18'(div_q[16:0]) - 18'(over);
            state  <= S_SM1;
          end
        end
        S_SM1: state <= S_SM2;
        S_SM2: begin
          acc   <= mul_p[39:0];
          state <= S_SM3;
        end
        S_SM3: begin
          sg    <= s_w[31:16];
          state <= S_MK;
        end
        S_MK: state <= S_MKW;
        S_MKW: begin
          ip    <= e_w[39:32];
          f     <= e_w[31:16];
          state <= S_FR;
        end
        S_FR: state <= S_FRW;
        S_FRW: begin
          y2    <= mul_p[45:16];
          term  <= ONE_Q30;
          sum   <= 32'(ONE_Q30);
          k     <= 4'd1;
          state <= S_EX;
        end
        S_EX: state <= S_EXW;
        S_EXW: state <= S_EXD;
        S_EXD: begin
          if (div_done) begin
            term <= div_q[30:0];
            sum  <= sum + div_q;
            k    <= k + 4'd1;
            state <= (k == EXP_TERMS) ? S_OUTM : S_EX;
          end
        end
        S_OUTM: state <= S_OUTW;
        S_OUTW: begin
          vres  <= v[SAMPLE_BITS-1:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            sample_out <= neg ? (~vres + 1'b1) : vres;
            gain_db    <= sg;
            out_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_gain_not_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain_db[15] || gain_db == 16'sd0))
    else $error("smoothed gain above zero dB");
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIVW || state == S_EXD))
    else $error("divider result arrived outside a wait state");
  a_series_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_EX || state == S_EXW || state == S_EXD) |-> (k >= 4'd1 && k <= EXP_TERMS))
    else $error("exp series term index out of range");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE)
    else $error("accepted item not started");
  a_change_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SM1 |-> (change[17] || change == 18'sd0))
    else $error("gain change above zero");

endmodule

// ----- hw/rtl/fc_div.sv -----
// radix-2 restoring divider shared by the gain computer and the exp series
`timescale 1ns / 1ps
module fc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fc_pkg::DIV_N_W-1:0]  dividend,
  input  logic [fc_pkg::DIV_D_W-1:0]  divisor,
  output logic                        done,
  output logic [fc_pkg::DIV_N_W-1:0]  quotient
);
  import fc_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);

  logic [DIV_N_W-1:0] dvd;
  logic [DIV_D_W-1:0] dsr;
  logic [DIV_D_W:0]   rem;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DIV_D_W:0]   rem_sh;
  logic               fits;

  assign rem_sh   = {rem[DIV_D_W-1:0], dvd[DIV_N_W-1]};
  assign fits     = rem_sh >= {1'b0, dsr};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_N_W);
        dvd  <= dividend;
        dsr  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        rem  <= fits ? (rem_sh - {1'b0, dsr}) : rem_sh;
        dvd  <= {dvd[DIV_N_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a running division");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy && !done |-> !start)
    else $error("divider restarted while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> rem < {1'b0, dsr})
    else $error("partial remainder out of range");

endmodule
